// ===== rtl/core/sad_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the sound activity detector.
// Used by sound_activity_detector and by its checker; depends on nothing else.
package sad_pkg;

    // Structure of the measurement.
    localparam int FRAMES_PER_BLOCK = 128;
    localparam int WINDOW_DEPTH     = 512;
    localparam int MAX_CHANNELS     = 8;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 15;
    localparam int GATE_W   = 16;
    localparam int LIMIT_W  = 10;
    localparam int CHAN_W   = 4;
    localparam int TOTAL_W  = 10;
    localparam int CFG_W    = 16;

    // Derived widths.
    localparam int SAMPLE_MAG_MAX = 32767;
    localparam int SUM_W  = $clog2(FRAMES_PER_BLOCK * SAMPLE_MAG_MAX + 1);
    localparam int FRM_W  = (FRAMES_PER_BLOCK > 1) ? $clog2(FRAMES_PER_BLOCK) : 1;
    localparam int CHP_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WIN_AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SPK_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W  = (SPK_W > TOTAL_W) ? SPK_W : TOTAL_W;
    localparam int TOTAL_MAX = (1 << TOTAL_W) - 1;

    // Register reset values.
    localparam logic [GATE_W-1:0]  GATE_RESET  = GATE_W'(4096);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(15);
    localparam logic [CHAN_W-1:0]  CHAN_RESET  = CHAN_W'(1);

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_GATE_LEVEL    = 2'd0,
        REG_SPIKE_LIMIT   = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } t_cfg_reg;

endpackage

// ===== rtl/core/sound_activity_detector.sv =====
`timescale 1ns / 1ps
// Energy based sound activity detector: block levels, ring window of levels
// held in one synchronous memory, spike count and detection edges. Uses sad_pkg.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  input   | i_in_valid / o_in_stall   | i_sample
//  output  | o_out_valid / i_out_stall | o_level, o_spike_total, o_detected,
//          |                           | o_start_mark, o_stop_mark
//  config  | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// One sample is taken per cycle while the input is not stalled. The sample
// that completes a block reads the oldest window entry; when the update stage
// advances, the entry is rewritten, the spike count updated and the result
// loaded into the output register. The window memory is read and written once
// per block, so blocks of one frame still run at one item per cycle while the
// output is not stalled. Reset is synchronous; the window memory is not
// cleared. A stalled output holds the update stage, which stalls the input.
module sound_activity_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [sad_pkg::SAMPLE_W-1:0] i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sad_pkg::LEVEL_W-1:0]       o_level,
    output logic [sad_pkg::TOTAL_W-1:0]       o_spike_total,
    output logic                              o_detected,
    output logic                              o_start_mark,
    output logic                              o_stop_mark,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [sad_pkg::CFG_W-1:0]         i_cfg_data
);

    // Configuration.
    logic [sad_pkg::GATE_W-1:0]  r_gate;
    logic [sad_pkg::LIMIT_W-1:0] r_limit;
    logic [sad_pkg::CHAN_W-1:0]  r_chan;
    logic                        cfg_hit;

    // Accumulation stage.
    logic [sad_pkg::CHP_W-1:0]   r_chan_pos;
    logic [sad_pkg::FRM_W-1:0]   r_frame_pos;
    logic [sad_pkg::SUM_W-1:0]   r_sum;
    logic [sad_pkg::WIN_AW-1:0]  r_ptr;
    logic [sad_pkg::FILL_W-1:0]  r_fill;

    // Window update stage.
    logic                        r_s1_valid;
    logic [sad_pkg::LEVEL_W-1:0] r_s1_level;
    logic [sad_pkg::WIN_AW-1:0]  r_s1_ptr;
    logic                        r_s1_full_before;
    logic                        r_s1_full_after;
    logic                        r_s1_fwd;
    logic [sad_pkg::LEVEL_W-1:0] r_s1_fwd_data;
    logic [sad_pkg::LEVEL_W-1:0] r_rd_data;
    logic [sad_pkg::SPK_W-1:0]   r_spike;
    logic                        r_prev_det;

    // Output register.
    logic                        r_out_valid;
    logic [sad_pkg::LEVEL_W-1:0] r_out_level;
    logic [sad_pkg::TOTAL_W-1:0] r_out_total;
    logic                        r_out_det;
    logic                        r_out_start;
    logic                        r_out_stop;

    logic [sad_pkg::LEVEL_W-1:0] window_mem [sad_pkg::WINDOW_DEPTH];

    logic                        adv;
    logic                        s1_fire;
    logic                        acc;
    logic                        blk_done;
    logic                        last_chan;
    logic                        last_frame;
    logic [sad_pkg::CHAN_W-1:0]  chans;
    logic [sad_pkg::LEVEL_W-1:0] mag;
    logic [sad_pkg::SUM_W-1:0]   n_sum;
    logic [sad_pkg::LEVEL_W-1:0] n_level;
    logic                        full_now;
    logic [sad_pkg::FILL_W-1:0]  n_fill;
    logic [sad_pkg::LEVEL_W-1:0] old_level;
    logic                        spk_dec;
    logic                        spk_inc;
    logic [sad_pkg::SPK_W-1:0]   n_spike;
    logic                        n_det;
    logic [sad_pkg::TOTAL_W-1:0] n_total;

    assign adv        = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && adv;
    assign o_in_stall = r_s1_valid && !adv;
    assign acc        = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_chan == '0) begin
            chans = sad_pkg::CHAN_W'(1);
        end else if (r_chan > sad_pkg::CHAN_W'(sad_pkg::MAX_CHANNELS)) begin
            chans = sad_pkg::CHAN_W'(sad_pkg::MAX_CHANNELS);
        end else begin
            chans = r_chan;
        end
    end

    // The most negative sample has no positive twin in 16 bits and saturates.
    always_comb begin
        if (!i_sample[sad_pkg::SAMPLE_W-1]) begin
            mag = i_sample[sad_pkg::LEVEL_W-1:0];
        end else if (i_sample[sad_pkg::SAMPLE_W-2:0] == '0) begin
            mag = sad_pkg::LEVEL_W'(sad_pkg::SAMPLE_MAG_MAX);
        end else begin
            mag = sad_pkg::LEVEL_W'(sad_pkg::SAMPLE_W'(-i_sample));
        end
    end

    assign last_chan  = (sad_pkg::CHAN_W'(r_chan_pos) + sad_pkg::CHAN_W'(1)) >= chans;
    assign last_frame = r_frame_pos == sad_pkg::FRM_W'(sad_pkg::FRAMES_PER_BLOCK - 1);
    assign blk_done   = acc && last_chan && last_frame;
    assign n_sum      = (r_chan_pos == '0) ? r_sum + sad_pkg::SUM_W'(mag) : r_sum;
    assign n_level    = sad_pkg::LEVEL_W'(n_sum / sad_pkg::FRAMES_PER_BLOCK);
    assign full_now   = r_fill >= sad_pkg::FILL_W'(sad_pkg::WINDOW_DEPTH);
    assign n_fill     = full_now ? r_fill : r_fill + sad_pkg::FILL_W'(1);

    always_comb begin
        cfg_hit = 1'b0;
        unique case (i_cfg_index)
            sad_pkg::REG_GATE_LEVEL,
            sad_pkg::REG_SPIKE_LIMIT,
            sad_pkg::REG_CHANNEL_COUNT: cfg_hit = i_cfg_we;
            default:                    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate  <= sad_pkg::GATE_RESET;
            r_limit <= sad_pkg::LIMIT_RESET;
            r_chan  <= sad_pkg::CHAN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sad_pkg::REG_GATE_LEVEL:    r_gate  <= i_cfg_data[sad_pkg::GATE_W-1:0];
                sad_pkg::REG_SPIKE_LIMIT:   r_limit <= i_cfg_data[sad_pkg::LIMIT_W-1:0];
                sad_pkg::REG_CHANNEL_COUNT: r_chan  <= i_cfg_data[sad_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Accumulation and window position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_pos  <= '0;
            r_frame_pos <= '0;
            r_sum       <= '0;
            r_ptr       <= '0;
            r_fill      <= '0;
        end else begin
            if (acc) begin
                if (!last_chan) begin
                    r_chan_pos <= r_chan_pos + sad_pkg::CHP_W'(1);
                    r_sum      <= n_sum;
                end else begin
                    r_chan_pos <= '0;
                    if (!last_frame) begin
                        r_frame_pos <= r_frame_pos + sad_pkg::FRM_W'(1);
                        r_sum       <= n_sum;
                    end else begin
                        r_frame_pos <= '0;
                        r_sum       <= '0;
                    end
                end
            end
            if (cfg_hit) begin
                r_ptr  <= '0;
                r_fill <= '0;
            end else if (blk_done) begin
                r_fill <= n_fill;
                if (r_ptr == sad_pkg::WIN_AW'(sad_pkg::WINDOW_DEPTH - 1)) begin
                    r_ptr <= '0;
                end else begin
                    r_ptr <= r_ptr + sad_pkg::WIN_AW'(1);
                end
            end
        end
    end

    // Window memory: read the oldest entry when a block completes, write the
    // new level back from the update stage.
    always_ff @(posedge i_clk) begin
        if (blk_done) begin
            r_rd_data <= window_mem[r_ptr];
        end
        if (s1_fire) begin
            window_mem[r_s1_ptr] <= r_s1_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (blk_done) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // A read in the same cycle as a write to the same entry sees the old word,
    // so the written level is forwarded.
    always_ff @(posedge i_clk) begin
        if (blk_done) begin
            r_s1_level       <= n_level;
            r_s1_ptr         <= r_ptr;
            r_s1_full_before <= full_now;
            r_s1_full_after  <= n_fill >= sad_pkg::FILL_W'(sad_pkg::WINDOW_DEPTH);
            r_s1_fwd         <= s1_fire && (r_s1_ptr == r_ptr);
            r_s1_fwd_data    <= r_s1_level;
        end
    end

    assign old_level = r_s1_fwd ? r_s1_fwd_data : r_rd_data;
    assign spk_dec   = r_s1_full_before && (sad_pkg::GATE_W'(old_level) > r_gate)
                       && (r_spike != '0);
    assign spk_inc   = sad_pkg::GATE_W'(r_s1_level) > r_gate;
    assign n_spike   = r_spike - sad_pkg::SPK_W'(spk_dec) + sad_pkg::SPK_W'(spk_inc);
    assign n_det     = r_s1_full_after
                       && (sad_pkg::CMP_W'(n_spike) > sad_pkg::CMP_W'(r_limit));
    assign n_total   = (sad_pkg::CMP_W'(n_spike) > sad_pkg::CMP_W'(sad_pkg::TOTAL_MAX))
                       ? sad_pkg::TOTAL_W'(sad_pkg::TOTAL_MAX)
                       : sad_pkg::TOTAL_W'(n_spike);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spike    <= '0;
            r_prev_det <= 1'b0;
        end else if (cfg_hit) begin
            r_spike <= '0;
        end else if (s1_fire) begin
            r_spike    <= n_spike;
            r_prev_det <= n_det;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_level <= r_s1_level;
            r_out_total <= n_total;
            r_out_det   <= n_det;
            r_out_start <= n_det && !r_prev_det;
            r_out_stop  <= !n_det && r_prev_det;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_level       = r_out_level;
    assign o_spike_total = r_out_total;
    assign o_detected    = r_out_det;
    assign o_start_mark  = r_out_start;
    assign o_stop_mark   = r_out_stop;

endmodule

// ===== rtl/core/sad_checker.sv =====
`timescale 1ns / 1ps
// Port level checks for sound_activity_detector, attached by a bind statement.
// Uses sad_pkg for field widths.
module sad_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [sad_pkg::LEVEL_W-1:0]         o_level,
    input logic [sad_pkg::TOTAL_W-1:0]         o_spike_total,
    input logic                                o_detected,
    input logic                                o_start_mark,
    input logic                                o_stop_mark
);

    // A result waiting on a stalled receiver keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_level)
            && $stable(o_spike_total) && $stable(o_detected))
        else $error("sad: stalled result changed");

    // A start mark only comes with detection, a stop mark only without it.
    a_start_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_mark |-> o_detected)
        else $error("sad: start mark without detection");

    a_stop_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stop_mark |-> !o_detected)
        else $error("sad: stop mark while detecting");

    // The input is only held back while a result is stalled downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("sad: input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("sad: result present after reset");

endmodule

bind sound_activity_detector sad_checker u_sad_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_level       (o_level),
    .o_spike_total (o_spike_total),
    .o_detected    (o_detected),
    .o_start_mark  (o_start_mark),
    .o_stop_mark   (o_stop_mark)
);
